>>> hw/rtl/pat_pkg.sv
// Shared constants, codes and word types for the positional array table.
`default_nettype none

package pat_pkg;

    // Table geometry
    localparam int DEPTH = 64;
    localparam int WIDTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    // Fixed field widths of the channel words
    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int ST_W   = 3;
    localparam int IDX_W  = 6;
    localparam int FILL_W = 7;

    // Common width for position vs. count compares
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_LSEARCH  = 3'd2,
        OP_BSEARCH  = 3'd3,
        OP_TRAVERSE = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef struct packed {
        op_t                     op;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } in_word_t;

    typedef struct packed {
        status_t                 status;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] entry_value;
        logic [FILL_W-1:0]       fill;
        logic                    last;
    } out_word_t;

    // Table memory access from the sequencer
    typedef struct packed {
        logic             we;
        logic [AW-1:0]    waddr;
        logic [WIDTH-1:0] wdata;
        logic             re;
        logic [AW-1:0]    raddr;
    } ram_req_t;

    // Compare unit result: stored entry vs. key
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_t;

endpackage

`default_nettype wire

>>> hw/rtl/positional_array_table_top.sv
// Positional array table: top level joining sequencer, compare unit and table RAM.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one request word: op, value, position.
//   Result channel m_valid/m_ready/m_data returns status, index, entry_value, fill, last.
//   Every request gives one result word, except traverse, which gives one word per
//   stored entry (last set on the final one); ops 5 to 7 are taken and dropped.
// Insert and delete shift the tail of the table from position one slot up or down;
// linear search reads from index 0 upward; binary search reads one midpoint per probe;
// traverse reads each stored entry in turn.
// The limit is the single RAM read port: a shift moves and a linear scan examines one entry per cycle.
// One request at a time: s_ready is high only while the sequencer is idle. The output
// register lets the next request in while the last result word still waits.
// Reset (aresetn low, synchronous) empties the table (count zero) and drops any
// pending result word; the RAM contents are not cleared and need no clearing pass.
// A stalled receiver (m_ready low) holds the result word; traverse waits at every output
// step and all other ops wait at their final step until the output register frees.
`default_nettype none

module positional_array_table_top
    import pat_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_word_t     m_data
);

    ram_req_t         ram_req;
    logic [WIDTH-1:0] ram_rdata;
    logic [WIDTH-1:0] cmp_key;
    cmp_t             cmp_res;

    // Sequencer: decodes requests, walks the table, owns the output register
    pat_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .cmp_key   (cmp_key),
        .cmp_res   (cmp_res)
    );

    // Shared compare: every search step checks the word on the read port
    pat_cmp u_cmp (
        .entry (ram_rdata),
        .key   (cmp_key),
        .res   (cmp_res)
    );

    // Table storage, DEPTH entries of WIDTH bits
    pat_ram #(
        .DATA_W (WIDTH),
        .DEPTH  (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/pat_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module pat_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pat_cmp.sv
// Shared compare unit: stored entry against the request key, signed order.
`default_nettype none

module pat_cmp
    import pat_pkg::*;
(
    input  wire logic [WIDTH-1:0] entry,
    input  wire logic [WIDTH-1:0] key,
    output cmp_t                  res
);

    always_comb begin
        res.eq = (entry == key);
        res.lt = ($signed(entry) < $signed(key));
    end

endmodule

`default_nettype wire

>>> hw/rtl/pat_seq.sv
// Request sequencer: shift, scan, halving search and traverse over the table RAM.
`default_nettype none

module pat_seq
    import pat_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_word_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_word_t             m_data,
    output ram_req_t              ram_req,
    input  wire logic [WIDTH-1:0] ram_rdata,
    output logic [WIDTH-1:0]      cmp_key,
    input  wire cmp_t             cmp_res
);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_INS_SHIFT = 13'b0000000000010,
        S_INS_PUT   = 13'b0000000000100,
        S_DEL_GET   = 13'b0000000001000,
        S_DEL_CAP   = 13'b0000000010000,
        S_DEL_SHIFT = 13'b0000000100000,
        S_LIN_SCAN  = 13'b0000001000000,
        S_BIN_RD    = 13'b0000010000000,
        S_BIN_CMP   = 13'b0000100000000,
        S_TRV_RD    = 13'b0001000000000,
        S_TRV_OUT   = 13'b0010000000000,
        S_EMIT      = 13'b0100000000000,
        S_SPARE     = 13'b1000000000000
    } state_t;

    typedef logic signed [CW:0] sidx_t;

    state_t           state_reg, state_next;
    logic [WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [AW-1:0]    wa_reg, wa_next;
    logic             pend_reg, pend_next;
    sidx_t            lo_reg, lo_next;
    sidx_t            hi_reg, hi_next;
    logic [CW-1:0]    mid_reg, mid_next;
    out_word_t        res_reg, res_next;
    out_word_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic          out_free;
    logic          out_load;
    out_word_t     out_word;
    logic [XW-1:0] pos_x, cnt_x;
    logic [CW-1:0] ptr_m1, ptr_p1;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic          trv_last;

    function automatic out_word_t err_word(status_t st, logic [CW-1:0] cnt);
        out_word_t w;
        w.status      = st;
        w.index       = '0;
        w.entry_value = '0;
        w.fill        = FILL_W'(cnt);
        w.last        = 1'b1;
        return w;
    endfunction

    function automatic out_word_t ok_word(logic [CW-1:0] idx, logic [WIDTH-1:0] val,
                                          logic [CW-1:0] cnt, logic last);
        out_word_t w;
        w.status      = ST_OK;
        w.index       = IDX_W'(idx);
        w.entry_value = VAL_W'(val);
        w.fill        = FILL_W'(cnt);
        w.last        = last;
        return w;
    endfunction

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign cmp_key  = key_reg;

    assign pos_x    = XW'(s_data.position);
    assign cnt_x    = XW'(cnt_reg);
    assign ptr_m1   = ptr_reg - CW'(1);
    assign ptr_p1   = ptr_reg + CW'(1);
    assign mid_sum  = {1'b0, lo_reg[CW-1:0]} + {1'b0, hi_reg[CW-1:0]};
    assign mid      = mid_sum[CW:1];
    assign trv_last = (ptr_p1 == cnt_reg);

    always_comb begin
        state_next = state_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        wa_next    = wa_reg;
        pend_next  = pend_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        res_next   = res_reg;
        out_load   = 1'b0;
        out_word   = res_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = wa_reg;
        ram_req.wdata = ram_rdata;
        ram_req.re    = 1'b0;
        ram_req.raddr = ptr_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    key_next  = WIDTH'(s_data.value);
                    pos_next  = CW'(s_data.position);
                    pend_next = 1'b0;
                    unique case (s_data.op)
                        OP_INSERT: begin
                            if (pos_x > cnt_x) begin
                                res_next   = err_word(ST_BAD_POS, cnt_reg);
                                state_next = S_EMIT;
                            end else if (cnt_reg == CW'(DEPTH)) begin
                                res_next   = err_word(ST_FULL, cnt_reg);
                                state_next = S_EMIT;
                            end else begin
                                ptr_next   = cnt_reg;
                                state_next = S_INS_SHIFT;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_x >= cnt_x) begin
                                res_next   = err_word(ST_BAD_POS, cnt_reg);
                                state_next = S_EMIT;
                            end else begin
                                state_next = S_DEL_GET;
                            end
                        end
                        OP_LSEARCH: begin
                            ptr_next   = '0;
                            state_next = S_LIN_SCAN;
                        end
                        OP_BSEARCH: begin
                            lo_next    = '0;
                            hi_next    = sidx_t'($signed({1'b0, cnt_reg}) - sidx_t'(1));
                            state_next = S_BIN_RD;
                        end
                        OP_TRAVERSE: begin
                            if (cnt_reg == '0) begin
                                res_next   = err_word(ST_EMPTY, cnt_reg);
                                state_next = S_EMIT;
                            end else begin
                                ptr_next   = '0;
                                state_next = S_TRV_RD;
                            end
                        end
                        default: begin
                            // unknown op: dropped, no result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // read ptr-1 while writing the previous word one slot up
            S_INS_SHIFT: begin
                ram_req.we = pend_reg;
                if (ptr_reg > pos_reg) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ptr_m1[AW-1:0];
                    wa_next       = ptr_reg[AW-1:0];
                    ptr_next      = ptr_m1;
                    pend_next     = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_INS_PUT;
                end
            end

            S_INS_PUT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg[AW-1:0];
                ram_req.wdata = key_reg;
                cnt_next      = cnt_reg + CW'(1);
                res_next      = ok_word(pos_reg, key_reg, cnt_reg + CW'(1), 1'b1);
                state_next    = S_EMIT;
            end

            S_DEL_GET: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = pos_reg[AW-1:0];
                ptr_next      = pos_reg;
                state_next    = S_DEL_CAP;
            end

            S_DEL_CAP: begin
                res_next   = ok_word(pos_reg, ram_rdata, cnt_reg - CW'(1), 1'b1);
                state_next = S_DEL_SHIFT;
            end

            // read ptr+1 while writing the previous word one slot down
            S_DEL_SHIFT: begin
                ram_req.we = pend_reg;
                if (ptr_p1 < cnt_reg) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ptr_p1[AW-1:0];
                    wa_next       = ptr_reg[AW-1:0];
                    ptr_next      = ptr_p1;
                    pend_next     = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_EMIT;
                end
            end

            // wa_reg holds the address of the word now on the read port
            S_LIN_SCAN: begin
                if (pend_reg && cmp_res.eq) begin
                    pend_next  = 1'b0;
                    res_next   = ok_word(CW'(wa_reg), key_reg, cnt_reg, 1'b1);
                    state_next = S_EMIT;
                end else if (ptr_reg < cnt_reg) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ptr_reg[AW-1:0];
                    wa_next       = ptr_reg[AW-1:0];
                    ptr_next      = ptr_p1;
                    pend_next     = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    res_next   = err_word(ST_NOT_FOUND, cnt_reg);
                    state_next = S_EMIT;
                end
            end

            S_BIN_RD: begin
                if (lo_reg <= hi_reg) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = mid[AW-1:0];
                    mid_next      = mid;
                    state_next    = S_BIN_CMP;
                end else begin
                    res_next   = err_word(ST_NOT_FOUND, cnt_reg);
                    state_next = S_EMIT;
                end
            end

            S_BIN_CMP: begin
                if (cmp_res.eq) begin
                    res_next   = ok_word(mid_reg, key_reg, cnt_reg, 1'b1);
                    state_next = S_EMIT;
                end else if (cmp_res.lt) begin
                    lo_next    = sidx_t'({1'b0, mid_reg}) + sidx_t'(1);
                    state_next = S_BIN_RD;
                end else begin
                    hi_next    = sidx_t'({1'b0, mid_reg}) - sidx_t'(1);
                    state_next = S_BIN_RD;
                end
            end

            S_TRV_RD: begin
                ram_req.re = 1'b1;
                state_next = S_TRV_OUT;
            end

            // read data holds on the RAM port until the output slot frees
            S_TRV_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_word   = ok_word(ptr_reg, ram_rdata, cnt_reg, trv_last);
                    ptr_next   = ptr_p1;
                    state_next = trv_last ? S_IDLE : S_TRV_RD;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_next       = out_word;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        pos_reg <= pos_next;
        ptr_reg <= ptr_next;
        wa_reg  <= wa_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/pat_chk.sv
// Port-level checker for the positional array table, bound to the top level.
`default_nettype none

module pat_chk
    import pat_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_word_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_word_t m_data
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // every known op leaves the block busy in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.op == OP_INSERT || s_data.op == OP_DELETE ||
        s_data.op == OP_LSEARCH || s_data.op == OP_BSEARCH ||
        s_data.op == OP_TRAVERSE) |=> !s_ready)
        else $error("request accepted while previous one in flight");

    // error results end the request
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.last)
        else $error("error result without last");

    // error results carry zero index and value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.index == '0 &&
        m_data.entry_value == '0)
        else $error("error result with nonzero payload");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind positional_array_table_top pat_chk u_chk (.*);

`default_nettype wire
